### hdl/b64enc_pkg.sv
// ----------------------------------------------------------------------------
// b64enc_pkg
// Shared types and helpers for the streaming base64 encoder.
// ----------------------------------------------------------------------------
package b64enc_pkg;

    localparam logic [6:0] PAD_CHAR = 7'h3D;

    // One classified group, passed from front end to back end
    typedef struct packed {
        logic [7:0] b0;
        logic [7:0] b1;
        logic [7:0] b2;
        logic [1:0] count;   // bytes of real data in the group, 1..3
        logic       last;    // group closes the message
    } group_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

    typedef struct packed {
        logic [1:0] position;
    } front_status_t;

    // Map a sextet to its character from the standard alphabet
    function automatic logic [6:0] sextet_to_char(input logic [5:0] six);
        logic [6:0] ch;
        if (six < 6'd26) begin
            ch = 7'h41 + {1'b0, six};
        end else if (six < 6'd52) begin
            ch = 7'h61 + {1'b0, six} - 7'd26;
        end else if (six < 6'd62) begin
            ch = 7'h30 + {1'b0, six} - 7'd52;
        end else if (six == 6'd62) begin
            ch = 7'h2B;
        end else begin
            ch = 7'h2F;
        end
        return ch;
    endfunction

endpackage

### hdl/b64enc_front.sv
// ----------------------------------------------------------------------------
// b64enc_front
// Takes raw bytes, holds the open group and pushes each closed group.
// ----------------------------------------------------------------------------
module b64enc_front import b64enc_pkg::*; (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_tvalid,
    output logic          s_tready,
    input  logic [7:0]    s_tdata,
    input  logic          s_tlast,
    input  q_status_t     q_status,
    output logic          push,
    output group_t        push_group,
    output front_status_t front_status
);

    logic [1:0] pos_reg, pos_next, pos_cur;
    logic [7:0] held0_reg, held0_next;
    logic [7:0] held1_reg, held1_next;
    logic       accept;

    assign s_tready = !q_status.full;
    assign accept   = s_tvalid && s_tready;
    // treat the unreachable position three as an empty group
    assign pos_cur  = (pos_reg == 2'd3) ? 2'd0 : pos_reg;
    assign front_status.position = pos_reg;

    // Classify the word: hold it or close the group
    always_comb begin
        pos_next   = pos_reg;
        held0_next = held0_reg;
        held1_next = held1_reg;
        push       = 1'b0;
        push_group = '0;
        if (accept) begin
            case (pos_cur)
                2'd0: begin
                    held0_next       = s_tdata;
                    push_group.b0    = s_tdata;
                    push_group.count = 2'd1;
                end
                2'd1: begin
                    held1_next       = s_tdata;
                    push_group.b0    = held0_reg;
                    push_group.b1    = s_tdata;
                    push_group.count = 2'd2;
                end
                default: begin
                    push_group.b0    = held0_reg;
                    push_group.b1    = held1_reg;
                    push_group.b2    = s_tdata;
                    push_group.count = 2'd3;
                end
            endcase
            push_group.last = s_tlast;
            push = s_tlast || (pos_cur == 2'd2);
            pos_next = push ? 2'd0 : pos_cur + 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg   <= 2'd0;
            held0_reg <= 8'd0;
            held1_reg <= 8'd0;
        end else begin
            pos_reg   <= pos_next;
            held0_reg <= held0_next;
            held1_reg <= held1_next;
        end
    end

endmodule

### hdl/b64enc_queue.sv
// ----------------------------------------------------------------------------
// b64enc_queue
// Two-entry queue of closed groups between front and back end.
// ----------------------------------------------------------------------------
module b64enc_queue import b64enc_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      push,
    input  group_t    push_group,
    input  logic      pop,
    output group_t    pop_group,
    output q_status_t q_status
);

    group_t     entry_reg [2];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] cnt_reg, cnt_next;

    assign q_status.empty = (cnt_reg == 2'd0);
    assign q_status.full  = (cnt_reg == 2'd2);
    assign pop_group      = entry_reg[rd_ptr_reg];

    // Track occupancy
    always_comb begin
        cnt_next = cnt_reg;
        if (push && !pop) begin
            cnt_next = cnt_reg + 2'd1;
        end else if (pop && !push) begin
            cnt_next = cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end else begin
            if (push) begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            cnt_reg <= cnt_next;
        end
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_group;
        end
    end

endmodule

### hdl/b64enc_back.sv
// ----------------------------------------------------------------------------
// b64enc_back
// Expands each group into four characters, one word per cycle while m_ is not stalled.
// ----------------------------------------------------------------------------
module b64enc_back import b64enc_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  q_status_t q_status,
    input  group_t    pop_group,
    output logic      pop,
    output logic      m_tvalid,
    input  logic      m_tready,
    output logic [7:0] m_tdata,
    output logic      m_tlast
);

    group_t     grp_reg;
    logic       busy_reg, busy_next;
    logic [1:0] idx_reg, idx_next;
    logic       valid_reg, valid_next;
    logic [6:0] char_reg, char_next;
    logic       last_reg, last_next;
    logic       out_free, emit;
    logic [5:0] sextet;

    assign out_free = !valid_reg || m_tready;
    assign emit     = busy_reg && out_free;
    assign pop      = !q_status.empty && (!busy_reg || (emit && idx_reg == 2'd3));

    // Pick the sextet for the current character
    always_comb begin
        case (idx_reg)
            2'd0:    sextet = grp_reg.b0[7:2];
            2'd1:    sextet = {grp_reg.b0[1:0], grp_reg.b1[7:4]};
            2'd2:    sextet = {grp_reg.b1[3:0], grp_reg.b2[7:6]};
            default: sextet = grp_reg.b2[5:0];
        endcase
    end

    // Advance the character counter and load the output register
    always_comb begin
        busy_next  = busy_reg;
        idx_next   = idx_reg;
        valid_next = valid_reg;
        char_next  = char_reg;
        last_next  = last_reg;
        if (out_free) begin
            valid_next = 1'b0;
        end
        if (emit) begin
            valid_next = 1'b1;
            char_next  = ({1'b0, idx_reg} > {1'b0, grp_reg.count}) ? PAD_CHAR
                                                                 : sextet_to_char(sextet);
            last_next  = grp_reg.last && (idx_reg == 2'd3);
            idx_next   = idx_reg + 2'd1;
            if (idx_reg == 2'd3) begin
                busy_next = 1'b0;
            end
        end
        if (pop) begin
            busy_next = 1'b1;
            idx_next  = 2'd0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg  <= 1'b0;
            idx_reg   <= 2'd0;
            valid_reg <= 1'b0;
        end else begin
            busy_reg  <= busy_next;
            idx_reg   <= idx_next;
            valid_reg <= valid_next;
        end
        char_reg <= char_next;
        last_reg <= last_next;
        if (pop) begin
            grp_reg <= pop_group;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = {1'b0, char_reg};
    assign m_tlast  = last_reg;

endmodule

### hdl/base64_stream_encoder.sv
// ----------------------------------------------------------------------------
// base64_stream_encoder
// Streaming base64 encoder, standard alphabet with '=' padding.
// ----------------------------------------------------------------------------
//  Channel | Dir | tdata            | tlast
//  s_      | in  | [7:0] data_byte  | last_byte
//  m_      | out | [6:0] out_char   | last_char
//
//  One character leaves per cycle while m_ is not stalled; the back end
//  walks the four characters of a closed group with its character counter.
//  Bytes are taken every cycle while the two-entry group queue has room.
//  Reset is synchronous on aresetn low and empties the queue and the group.
//  Stalls on m_ back up into the queue; s_tready drops while it holds two
//  groups.
module base64_stream_encoder import b64enc_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,    // [7:0] data_byte
    input  logic       s_tlast,
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,    // [6:0] out_char, [7] zero
    output logic       m_tlast
);

    q_status_t     q_status;
    front_status_t front_status;
    group_t        push_group, pop_group;
    logic          push, pop;

    b64enc_front u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .s_tlast      (s_tlast),
        .q_status     (q_status),
        .push         (push),
        .push_group   (push_group),
        .front_status (front_status)
    );

    b64enc_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_group (push_group),
        .pop        (pop),
        .pop_group  (pop_group),
        .q_status   (q_status)
    );

    b64enc_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .q_status  (q_status),
        .pop_group (pop_group),
        .pop       (pop),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    // Queue never reports full and empty together
    assert property (@(posedge aclk) disable iff (!aresetn)
        !(q_status.full && q_status.empty))
        else $error("group queue full and empty at once");

    // A final byte always closes the open group
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && s_tlast) |=> (front_status.position == 2'd0))
        else $error("group left open after last byte");

    // Position three is never reached
    assert property (@(posedge aclk) disable iff (!aresetn)
        front_status.position != 2'd3)
        else $error("group position out of range");

    // No push into a full queue unless a pop frees an entry in the same cycle
    assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> (!q_status.full || pop))
        else $error("push into full group queue");

endmodule

### tb/tb_base64_stream_encoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_base64_stream_encoder
// Self-checking bench for the streaming base64 encoder. A queue of raw
// message bytes feeds a clocked driver on the s_ channel. Each accepted word
// updates a local encoder model that queues the characters it should produce.
// A clocked monitor on the m_ channel compares every character and its last
// flag with the oldest queued one. Both sides idle at random.
// ----------------------------------------------------------------------------
module tb_base64_stream_encoder;

    localparam int         IDLE_LIMIT = 1000;
    localparam int         TAIL_CYCLES = 16;
    localparam int         MSG_TARGET = 360;
    localparam logic [6:0] EQ_PAD = 7'h3D;

    // One raw byte as queued for the driver
    typedef struct {
        logic [7:0] data;
        logic       last;
        logic       drain;   // hold until every queued character has come
    } raw_word_t;

    // One encoded character as the monitor expects it
    typedef struct {
        logic [6:0] ch;
        logic       last;
    } char_word_t;

    logic       aclk = 1'b0;
    logic       aresetn = 1'b0;
    logic       s_tvalid = 1'b0;
    logic       s_tready;
    logic [7:0] s_tdata = '0;    // [7:0] data_byte
    logic       s_tlast = 1'b0;
    logic       m_tvalid;
    logic       m_tready = 1'b0;
    logic [7:0] m_tdata;         // [6:0] out_char, [7] zero
    logic       m_tlast;

    string      b64_alphabet =
        "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

    raw_word_t  raw_bytes[$];
    char_word_t char_expect[$];
    raw_word_t  next_raw;

    // Local encoder state
    logic [7:0] grp_byte0 = '0;
    logic [7:0] grp_byte1 = '0;
    logic [1:0] grp_fill = '0;

    bit         byte_taken = 1'b0;
    bit         char_taken = 1'b0;
    bit         send_calm = 1'b0;
    bit         recv_calm = 1'b0;
    int         send_gap = 0;
    int         recv_gap = 0;
    int         idle_cycles = 0;
    int         errors = 0;

    base64_stream_encoder u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // Queue the four characters of one group, padding the missing bytes
    task automatic queue_group(input logic [7:0] b0, input logic [7:0] b1,
                               input logic [7:0] b2, input int count,
                               input logic fin);
        logic [5:0] sx[4];
        char_word_t cw;
        sx[0] = b0[7:2];
        sx[1] = {b0[1:0], b1[7:4]};
        sx[2] = {b1[3:0], b2[7:6]};
        sx[3] = b2[5:0];
        for (int k = 0; k < 4; k++) begin
            cw.ch = (k <= count) ? 7'(b64_alphabet[sx[k]]) : EQ_PAD;
            cw.last = (k == 3) ? fin : 1'b0;
            char_expect.push_back(cw);
        end
    endtask

    // Advance the encoder model by one accepted byte
    task automatic encode_byte(input logic [7:0] b, input logic fin);
        logic [1:0] pos;
        pos = (grp_fill == 2'd3) ? 2'd0 : grp_fill;
        case (pos)
            2'd0: begin
                grp_byte0 = b;
                if (fin) begin
                    queue_group(grp_byte0, 8'h00, 8'h00, 1, 1'b1);
                    grp_fill = 2'd0;
                end else begin
                    grp_fill = 2'd1;
                end
            end
            2'd1: begin
                grp_byte1 = b;
                if (fin) begin
                    queue_group(grp_byte0, grp_byte1, 8'h00, 2, 1'b1);
                    grp_fill = 2'd0;
                end else begin
                    grp_fill = 2'd2;
                end
            end
            default: begin
                queue_group(grp_byte0, grp_byte1, b, 3, fin);
                grp_fill = 2'd0;
            end
        endcase
    endtask

    // Append one message to the byte queue
    task automatic add_message(input logic [7:0] bytes[$], input logic drain);
        raw_word_t rw;
        for (int k = 0; k < bytes.size(); k++) begin
            rw.data = bytes[k];
            rw.last = (k == bytes.size() - 1);
            rw.drain = drain && (k == 0);
            raw_bytes.push_back(rw);
        end
    endtask

    // Drive the s_ channel on the falling edge
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            s_tdata <= '0;
            s_tlast <= 1'b0;
        end else if (!s_tvalid || byte_taken) begin
            byte_taken = 1'b0;
            if (send_gap != 0) begin
                send_gap--;
                s_tvalid <= 1'b0;
            end else if (raw_bytes.size() != 0 &&
                         !(raw_bytes[0].drain && char_expect.size() != 0)) begin
                next_raw = raw_bytes.pop_front();
                s_tvalid <= 1'b1;
                s_tdata <= next_raw.data;
                s_tlast <= next_raw.last;
                send_gap = send_calm ? 0 : $urandom_range(0, 5);
                if ($urandom_range(0, 29) == 0) send_calm = !send_calm;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Drive m_tready on the falling edge, one random wait per character
    always @(negedge aclk) begin
        if (char_taken) begin
            char_taken = 1'b0;
            recv_gap = recv_calm ? 0 : $urandom_range(0, 5);
            if ($urandom_range(0, 39) == 0) recv_calm = !recv_calm;
        end
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (recv_gap != 0) begin
            recv_gap--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    // Sample both channels on the rising edge: predict, check, watch
    always @(posedge aclk) begin
        char_word_t want;
        if (aresetn && s_tvalid && s_tready) begin
            byte_taken = 1'b1;
            encode_byte(s_tdata, s_tlast);
        end
        if (aresetn && m_tvalid && m_tready) begin
            char_taken = 1'b1;
            if (char_expect.size() == 0) begin
                $display("%0t: unexpected word tdata=%02h tlast=%b",
                         $time, m_tdata, m_tlast);
                errors++;
            end else begin
                want = char_expect.pop_front();
                if (m_tdata !== {1'b0, want.ch}) begin
                    $display("%0t: out_char expected %02h actual %02h",
                             $time, {1'b0, want.ch}, m_tdata);
                    errors++;
                end
                if (m_tlast !== want.last) begin
                    $display("%0t: last_char expected %b actual %b",
                             $time, want.last, m_tlast);
                    errors++;
                end
            end
        end
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
        end
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial begin
        logic [7:0] msg[$];
        int         len;
        int         flavour;

        // Directed: single byte, two bytes, full groups, full then partial
        msg = '{8'h00};                      add_message(msg, 1'b0);
        msg = '{8'hFF};                      add_message(msg, 1'b0);
        msg = '{8'hFF, 8'h00};               add_message(msg, 1'b0);
        msg = '{8'h00, 8'hFF};               add_message(msg, 1'b1);
        msg = '{8'h00, 8'h00, 8'h00};        add_message(msg, 1'b0);
        msg = '{8'hFF, 8'hFF, 8'hFF};        add_message(msg, 1'b0);
        msg = '{8'hFB, 8'hEF, 8'hBE};        add_message(msg, 1'b0);
        msg = '{8'h4D, 8'h61, 8'h6E, 8'h61}; add_message(msg, 1'b1);
        msg = '{8'h66, 8'h6F, 8'h6F, 8'h62, 8'h61};
        add_message(msg, 1'b0);

        // Random messages, mostly short, some with extreme content
        while (raw_bytes.size() < MSG_TARGET) begin
            msg.delete();
            len = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 24)
                                               : $urandom_range(1, 9);
            flavour = $urandom_range(0, 9);
            for (int k = 0; k < len; k++) begin
                case (flavour)
                    0:       msg.push_back(8'h00);
                    1:       msg.push_back(8'hFF);
                    2:       msg.push_back($urandom_range(0, 1) ? 8'hFF : 8'h00);
                    default: msg.push_back(8'($urandom()));
                endcase
            end
            add_message(msg, $urandom_range(0, 19) == 0);
        end

        // Hold reset, release on a falling edge
        repeat (7) @(negedge aclk);
        aresetn <= 1'b1;

        while (raw_bytes.size() != 0 || s_tvalid) @(posedge aclk);
        while (char_expect.size() != 0) @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);

        if (errors == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
